FILE: sv/index_dedup_remap_macros.svh
// Assertion macros used by the index_dedup_remap checker.
`ifndef INDEX_DEDUP_REMAP_MACROS_SVH
`define INDEX_DEDUP_REMAP_MACROS_SVH

// Same-cycle implication, sampled on clk, held off during reset
`define IDR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("index_dedup_remap: same-cycle check failed");

// Next-cycle implication, sampled on clk, held off during reset
`define IDR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("index_dedup_remap: next-cycle check failed");

`endif

FILE: sv/idr_pkg.sv
// Types and constants shared by the index_dedup_remap block.
`default_nettype none

package idr_pkg;

    // Result classification
    typedef enum logic [1:0] {
        KIND_NEW    = 2'd0,
        KIND_REPEAT = 2'd1,
        KIND_SKIP   = 2'd2,
        KIND_FULL   = 2'd3
    } idr_kind_t;

    // Input transaction
    typedef struct packed {
        logic [31:0] raw_index;
        logic        last_in;
    } idr_request_t;

    // Result transaction
    typedef struct packed {
        idr_kind_t   kind;
        logic [7:0]  out_index;
        logic [31:0] source_vertex;
        logic        last_out;
    } idr_response_t;

    // Classified item passed from the front end to the lookup engine
    typedef struct packed {
        logic [31:0] source_vertex;
        logic        last;
        logic        restart;
    } idr_entry_t;

    // Lookup engine states
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_CHECK,
        BK_SEARCH,
        BK_RESPOND
    } idr_back_state_t;

    localparam logic [31:0] RESTART_VERTEX = 32'hFFFF_FFFF;
    localparam int          QUEUE_DEPTH    = 2;

endpackage

`default_nettype wire

FILE: sv/idr_front.sv
// Front end: base vertex register, index rebasing and restart detection.
`default_nettype none

module idr_front
    import idr_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [31:0]  cfg_wdata,
    input  wire logic         start,
    input  wire idr_request_t request,
    input  wire logic         queue_full,
    output logic              busy,
    output logic              push,
    output idr_entry_t        push_entry
);

    logic [31:0] base_reg;
    logic [31:0] source_vertex;

    // Hold the base vertex offset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
        end
        else if (cfg_we)
        begin
            base_reg <= cfg_wdata;
        end
    end

    // Rebase the index modulo 2^32 and flag restarts
    always_comb
    begin
        source_vertex            = request.raw_index + base_reg;
        push_entry.source_vertex = source_vertex;
        push_entry.last          = request.last_in;
        push_entry.restart       = (source_vertex == RESTART_VERTEX);
    end

    // Take a transaction whenever the queue has room
    assign busy = queue_full;
    assign push = start && !queue_full;

endmodule

`default_nettype wire

FILE: sv/idr_fifo.sv
// Short queue between the front end and the lookup engine.
`default_nettype none

module idr_fifo
    import idr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire idr_entry_t push_entry,
    input  wire logic       pop,
    output idr_entry_t      pop_entry,
    output logic            empty,
    output logic            full
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    idr_entry_t    slot_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] fill_reg;
    logic          do_push;
    logic          do_pop;

    assign empty     = (fill_reg == '0);
    assign full      = (fill_reg == CW'(QUEUE_DEPTH));
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign pop_entry = slot_reg[rd_ptr_reg];

    // Store pushed entries
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // Advance pointers and track fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: sv/idr_back.sv
// Lookup engine: scans the unique vertex table and appends new vertices.
`default_nettype none

module idr_back
    import idr_pkg::*;
#(
    parameter int MAX_UNIQUE = 256
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       queue_empty,
    input  wire idr_entry_t queue_entry,
    output logic            pop,
    output logic            done,
    output idr_response_t   response
);

    localparam int AW = (MAX_UNIQUE > 1) ? $clog2(MAX_UNIQUE) : 1;
    localparam int CW = $clog2(MAX_UNIQUE + 1);

    idr_back_state_t state_reg;
    idr_back_state_t state_next;

    // Item under work
    logic [31:0]     src_reg;
    logic            last_reg;
    logic            restart_reg;

    // Table bookkeeping and scan
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   scan_reg;
    logic            cmp_valid_reg;
    logic [AW-1:0]   cmp_pos_reg;

    // Result
    idr_kind_t       kind_reg;
    logic [AW-1:0]   pos_reg;

    // Unique vertex table, single port
    logic [31:0]     table_mem [MAX_UNIQUE];
    logic [31:0]     mem_q;
    logic            mem_we;
    logic [AW-1:0]   mem_addr;

    logic            match;
    logic            scan_done;
    logic            has_room;
    logic            skip_now;
    logic            hit_now;
    logic            miss_now;
    logic            issue;

    // Decode lookup outcome
    always_comb
    begin
        match     = cmp_valid_reg && (mem_q == src_reg);
        scan_done = (scan_reg == count_reg);
        has_room  = (count_reg < CW'(MAX_UNIQUE));
        skip_now  = (state_reg == BK_CHECK) && restart_reg;
        hit_now   = (state_reg == BK_SEARCH) && match;
        miss_now  = ((state_reg == BK_CHECK) && !restart_reg && (count_reg == '0))
                 || ((state_reg == BK_SEARCH) && !match && scan_done && cmp_valid_reg);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!queue_empty)
                begin
                    state_next = BK_CHECK;
                end
            end
            BK_CHECK:
            begin
                state_next = (skip_now || miss_now) ? BK_RESPOND : BK_SEARCH;
            end
            BK_SEARCH:
            begin
                if (hit_now || miss_now)
                begin
                    state_next = BK_RESPOND;
                end
            end
            BK_RESPOND:
            begin
                state_next = BK_IDLE;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        pop      = (state_reg == BK_IDLE) && !queue_empty;
        done     = (state_reg == BK_RESPOND);
        issue    = (state_reg == BK_SEARCH) && !scan_done && !match;
        mem_we   = miss_now && has_room;
        mem_addr = mem_we ? count_reg[AW-1:0] : scan_reg[AW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Table write and registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[mem_addr] <= src_reg;
        end
        mem_q <= table_mem[mem_addr];
    end

    // Advance fill count and scan pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            scan_reg      <= '0;
            cmp_valid_reg <= 1'b0;
        end
        else
        begin
            if (done && last_reg)
            begin
                count_reg <= '0;
            end
            else if (mem_we)
            begin
                count_reg <= count_reg + 1'b1;
            end

            if (state_reg == BK_CHECK)
            begin
                scan_reg <= '0;
            end
            else if (issue)
            begin
                scan_reg <= scan_reg + 1'b1;
            end

            cmp_valid_reg <= issue;
        end
    end

    // Capture popped item, compare position and result
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            src_reg     <= queue_entry.source_vertex;
            last_reg    <= queue_entry.last;
            restart_reg <= queue_entry.restart;
        end

        cmp_pos_reg <= scan_reg[AW-1:0];

        if (skip_now)
        begin
            kind_reg <= KIND_SKIP;
            pos_reg  <= '0;
        end
        else if (hit_now)
        begin
            kind_reg <= KIND_REPEAT;
            pos_reg  <= cmp_pos_reg;
        end
        else if (miss_now)
        begin
            kind_reg <= has_room ? KIND_NEW : KIND_FULL;
            pos_reg  <= has_room ? count_reg[AW-1:0] : '0;
        end
    end

    assign response.kind          = kind_reg;
    assign response.out_index     = 8'(pos_reg);
    assign response.source_vertex = src_reg;
    assign response.last_out      = last_reg;

endmodule

`default_nettype wire

FILE: sv/index_dedup_remap.sv
// Top level of the index deduplication and remap block.
//
//   channel   direction  handshake                  payload
//   request   in         start & !busy              idr_request_t
//   response  out        done (one-cycle strobe)    idr_response_t
//   config    in         cfg_we                     cfg_wdata (base_vertex)
//
// An accepted item is queued, then passes through the lookup states CHECK,
// SEARCH and RESPOND, with SEARCH skipped for a restart or an empty table;
// the lookup reads one entry per cycle from the single-port table memory.
// Time spent queued behind earlier transactions delays done further.
// Reset clears the base vertex, the queue and the table fill count.
// busy rises when the two-entry queue is full; results are never held.
`default_nettype none

module index_dedup_remap
    import idr_pkg::*;
#(
    parameter int MAX_UNIQUE = 256
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [31:0]  cfg_wdata,
    input  wire logic         start,
    input  wire idr_request_t request,
    output logic              busy,
    output logic              done,
    output idr_response_t     response
);

    logic       queue_full;
    logic       queue_empty;
    logic       push;
    logic       pop;
    idr_entry_t push_entry;
    idr_entry_t pop_entry;

    // Classify incoming transactions
    idr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .start      (start),
        .request    (request),
        .queue_full (queue_full),
        .busy       (busy),
        .push       (push),
        .push_entry (push_entry)
    );

    // Decouple front end from the lookup engine
    idr_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .empty      (queue_empty),
        .full       (queue_full)
    );

    // Look up and append vertices
    idr_back #(
        .MAX_UNIQUE (MAX_UNIQUE)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .queue_entry (pop_entry),
        .pop         (pop),
        .done        (done),
        .response    (response)
    );

endmodule

`default_nettype wire

FILE: sv/idr_checker.sv
// Port-level checker for index_dedup_remap and its bind.
`default_nettype none

`include "index_dedup_remap_macros.svh"

module idr_checker
    import idr_pkg::*;
(
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          done,
    input wire idr_response_t response
);

    logic restart_seen;
    logic no_position;

    assign restart_seen = (response.source_vertex == RESTART_VERTEX);
    assign no_position  = (response.kind == KIND_SKIP) || (response.kind == KIND_FULL);

    // Restart results exactly when the rebased vertex is all ones
    `IDR_ASSERT_NOW(a_skip_iff_restart, done, (response.kind == KIND_SKIP) == restart_seen)

    // Skipped and full results carry no table position
    `IDR_ASSERT_NOW(a_no_position_zero, done && no_position, response.out_index == 8'd0)

    // Each result strobe lasts a single cycle
    `IDR_ASSERT_NEXT(a_done_single, done, !done)

endmodule

bind index_dedup_remap idr_checker u_idr_checker (.*);

`default_nettype wire
